[hdl/bcmc_pkg.sv]
// Shared types and constants for the box collision mask checker.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bcmc_pkg;

	// Mask store geometry.
	localparam int STORE_ADDR_W = 15;
	localparam int WORD_W       = 32;
	localparam int BITSEL_W     = 5;

	// Stream payload layout.
	localparam int POS_W        = 20;
	localparam int COORD_W      = 21;
	localparam int SIZE_W       = 10;
	localparam int S_TDATA_W    = 112;
	localparam int M_TDATA_W    = 8;

	// Inset of the sample box, 4.0 units in Q15.4.
	localparam int INSET_Q4     = 64;

	// Width of the point counter; eight points are sampled per box query.
	localparam int POINT_CNT_W  = 3;

	// Item kind carried on the slave tuser.
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	// One access to the single-port mask memory.
	typedef struct packed {
		logic                    we;
		logic [STORE_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]       wdata;
	} ram_req_t;

	// Sideband that travels with each sample point down the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} pt_tag_t;

endpackage

`default_nettype wire

[hdl/bcmc_mask_ram.sv]
// Single-port synchronous mask memory, one access per cycle, registered read.
// Depends on bcmc_pkg for the request struct and word geometry.
`timescale 1ns / 1ps
`default_nettype none

module bcmc_mask_ram
	import bcmc_pkg::*;
(
	input  wire logic              clk,
	input  wire ram_req_t          req,
	output logic [WORD_W-1:0]      rdata
);

	localparam int DEPTH = 1 << STORE_ADDR_W;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Write or read at the requested address; read data appears next cycle.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/bcmc_axis.sv]
// Maps one Q15.4 coordinate to a chunk index and a mask cell on one axis.
// Two pipeline stages; depends on bcmc_pkg for coordinate widths.
`timescale 1ns / 1ps
`default_nettype none

module bcmc_axis
	import bcmc_pkg::*;
#(
	parameter int COUNT       = 4,
	parameter int MASK_CELLS  = 256,
	parameter int CHUNK_UNITS = 1024,
	parameter int WORLD_UNITS = 4096,
	localparam int CHUNK_W    = (COUNT > 1) ? $clog2(COUNT) : 1,
	localparam int CELL_W     = $clog2(MASK_CELLS)
) (
	input  wire logic                      clk,
	input  wire logic signed [COORD_W-1:0] coord,
	output logic                           in_world_s2,
	output logic [CHUNK_W-1:0]             chunk_s2,
	output logic [CELL_W-1:0]              cell_s2
);

	// Chunk span and world limit in Q4 units.
	localparam int SPAN  = CHUNK_UNITS * 16;
	localparam int LIMIT = WORLD_UNITS * 16;
	localparam int LOC_W = $clog2(SPAN);
	// floor(loc * MASK_CELLS / SPAN) as a multiply by a rounded-up reciprocal.
	// With loc below SPAN and SHIFT = 2 * LOC_W the result is exact.
	localparam int SHIFT = 2 * LOC_W;
	localparam longint unsigned RECIP =
		((longint'(MASK_CELLS) << SHIFT) + longint'(SPAN) - 1) / longint'(SPAN);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = LOC_W + RECIP_W;

	logic [POS_W-1:0]   mag;
	logic               in_world;
	logic [CHUNK_W-1:0] chunk;
	logic [POS_W-1:0]   base;
	logic [POS_W-1:0]   loc_full;
	logic               over;

	logic               in_world_s1;
	logic [CHUNK_W-1:0] chunk_s1;
	logic               over_s1;
	logic [LOC_W-1:0]   loc_s1;

	logic [PROD_W-1:0]  prod;
	logic [CELL_W-1:0]  cell_sel;

	assign mag      = coord[POS_W-1:0];
	assign in_world = !coord[COORD_W-1] && (32'(mag) < 32'(LIMIT));

	// Chunk index by comparing against every chunk boundary; the last chunk
	// takes everything beyond it.
	always_comb begin
		chunk = '0;
		base  = '0;
		for (int k = 1; k < COUNT; k++) begin
			if (32'(mag) >= 32'(k * SPAN)) begin
				chunk = CHUNK_W'(k);
				base  = POS_W'(k * SPAN);
			end
		end
	end

	assign loc_full = mag - base;
	assign over     = (32'(loc_full) >= 32'(SPAN));

	// Stage 1: chunk found, offset inside the chunk.
	always_ff @(posedge clk) begin
		in_world_s1 <= in_world;
		chunk_s1    <= chunk;
		over_s1     <= over;
		loc_s1      <= loc_full[LOC_W-1:0];
	end

	// Cell index; an offset past the chunk clamps to the last cell.
	assign prod     = PROD_W'(loc_s1) * PROD_W'(RECIP);
	assign cell_sel = over_s1 ? CELL_W'(MASK_CELLS - 1) : prod[SHIFT +: CELL_W];

	// Stage 2: chunk and cell ready for address forming.
	always_ff @(posedge clk) begin
		in_world_s2 <= in_world_s1;
		chunk_s2    <= chunk_s1;
		cell_s2     <= cell_sel;
	end

endmodule

`default_nettype wire

[hdl/box_collision_mask_check.sv]
// Box collision mask checker.
//
// Slave stream: tuser carries the item kind. A write item stores one 32-bit
// mask word and gives no result. A query item samples eight points of the
// box inset by 4 units and gives one result on the master stream: bit 0 is 1
// when all eight points are walkable.
// cfg_we / cfg_wdata set masks_loaded; while it is 0 every query reports 1.
//
// A query holds tready low from its transfer until its result enters the
// output register: eight serial reads of the single-port mask memory, one per
// cycle, behind a four-stage address pipeline (axis map, multiply, address,
// memory read). The result is valid on the master stream as tready returns
// high. A write leaves the block ready for the next item.
//
// After reset the block sweeps all 32768 mask words to all ones with tready
// low; configuration writes are taken meanwhile.
// The result sits in an output register, so the next item is taken while it
// waits. If the receiver stalls, a second query finishes and holds until
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module box_collision_mask_check
	import bcmc_pkg::*;
#(
	parameter int CHUNK_ROW_COUNT = 4,
	parameter int CHUNK_COL_COUNT = 4,
	parameter int MASK_CELLS      = 256,
	parameter int CHUNK_UNITS     = 1024,
	parameter int WORLD_UNITS_X   = 4096,
	parameter int WORLD_UNITS_Y   = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,     // masks_loaded
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// pos_x[19:0], pos_y[39:20], box_width[49:40], box_height[59:50],
	// mask_addr[74:60], mask_data[106:75], zero fill [111:107]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// command[0]
	input  wire logic [0:0]           s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// box_clear[0], zero fill [7:1]
	output logic [M_TDATA_W-1:0]      m_axis_tdata
);

	localparam int COL_W   = (CHUNK_COL_COUNT > 1) ? $clog2(CHUNK_COL_COUNT) : 1;
	localparam int ROW_W   = (CHUNK_ROW_COUNT > 1) ? $clog2(CHUNK_ROW_COUNT) : 1;
	localparam int CELL_W  = $clog2(MASK_CELLS);
	localparam int CHK_N   = CHUNK_ROW_COUNT * CHUNK_COL_COUNT;
	localparam int CHK_W   = (CHK_N > 1) ? $clog2(CHK_N) : 1;
	localparam int BIT_RAW = $clog2(CHK_N * MASK_CELLS * MASK_CELLS);
	// At least 20 bits so the word index can always be taken from [19:5].
	localparam int BIT_W   = (BIT_RAW > 20) ? BIT_RAW : 20;

	// Payload fields.
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic [SIZE_W-1:0]        box_width;
	logic [SIZE_W-1:0]        box_height;
	logic [STORE_ADDR_W-1:0]  mask_addr;
	logic [WORD_W-1:0]        mask_data;
	cmd_t                     command;

	assign pos_x      = s_axis_tdata[19:0];
	assign pos_y      = s_axis_tdata[39:20];
	assign box_width  = s_axis_tdata[49:40];
	assign box_height = s_axis_tdata[59:50];
	assign mask_addr  = s_axis_tdata[74:60];
	assign mask_data  = s_axis_tdata[106:75];
	assign command    = cmd_t'(s_axis_tuser[0]);

	state_t                   state_q;
	state_t                   state_d;
	logic [STORE_ADDR_W-1:0]  clr_q;
	logic [POINT_CNT_W-1:0]   pc_q;
	logic                     masks_loaded_q;
	logic                     acc_q;
	logic                     done_q;
	logic                     out_valid_q;
	logic                     box_clear_q;

	logic                     s_accept;
	logic                     q_accept;
	logic                     feed;
	logic                     out_load;
	ram_req_t                 ram_req;
	logic [WORD_W-1:0]        ram_rdata;

	// Sample box edges in Q15.4.
	logic signed [COORD_W-1:0] x_ext;
	logic signed [COORD_W-1:0] y_ext;
	logic signed [COORD_W-1:0] l_q, r_q, cx_q, b_q, t_q, cy_q;
	logic signed [COORD_W-1:0] px, py;

	// Point pipeline.
	pt_tag_t                  tag_s1, tag_s2, tag_s3, tag_s4;
	logic                     xin_s2, yin_s2;
	logic [COL_W-1:0]         col_s2;
	logic [ROW_W-1:0]         row_s2;
	logic [CELL_W-1:0]        mx_s2, my_s2;
	logic [CHK_W-1:0]         chunk_idx;
	logic [BIT_W-1:0]         bit_idx;
	logic [STORE_ADDR_W-1:0]  addr_s3;
	logic [BITSEL_W-1:0]      sel_s3, sel_s4;
	logic                     solid_s3, solid_s4;
	logic                     point_open;

	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign q_accept = s_accept && (command == CMD_QUERY);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (pc_q == '1) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (done_q && (!out_valid_q || m_axis_tready)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, point feed and memory port selection.
	always_comb begin
		s_axis_tready = 1'b0;
		feed          = 1'b0;
		out_load      = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.addr  = addr_s3;
		ram_req.wdata = '1;
		case (state_q)
			ST_CLEAR: begin
				ram_req.we   = 1'b1;
				ram_req.addr = clr_q;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				ram_req.we    = s_accept && (command == CMD_WRITE);
				ram_req.addr  = mask_addr;
				ram_req.wdata = mask_data;
			end
			ST_RUN: begin
				feed = 1'b1;
			end
			ST_WAIT: begin
				out_load = done_q && (!out_valid_q || m_axis_tready);
			end
			default: begin
				feed = 1'b0;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (q_accept) begin
				pc_q <= '0;
			end else if (feed) begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_loaded_q <= 1'b0;
		end else if (cfg_we) begin
			masks_loaded_q <= cfg_wdata;
		end
	end

	// Sample box edges, captured at the query transfer.
	assign x_ext = COORD_W'(pos_x);
	assign y_ext = COORD_W'(pos_y);

	always_ff @(posedge clk) begin
		if (q_accept) begin
			l_q  <= x_ext + COORD_W'(INSET_Q4);
			r_q  <= x_ext + COORD_W'({box_width, 4'd0}) - COORD_W'(INSET_Q4);
			cx_q <= x_ext + COORD_W'({box_width, 3'd0});
			b_q  <= y_ext + COORD_W'(INSET_Q4);
			t_q  <= y_ext + COORD_W'({box_height, 4'd0}) - COORD_W'(INSET_Q4);
			cy_q <= y_ext + COORD_W'({box_height, 3'd0});
		end
	end

	// Pick the sample point for this cycle: bottom row, middle row, top row.
	always_comb begin
		case (pc_q)
			3'd0: begin px = l_q;  py = b_q;  end
			3'd1: begin px = cx_q; py = b_q;  end
			3'd2: begin px = r_q;  py = b_q;  end
			3'd3: begin px = l_q;  py = cy_q; end
			3'd4: begin px = r_q;  py = cy_q; end
			3'd5: begin px = l_q;  py = t_q;  end
			3'd6: begin px = cx_q; py = t_q;  end
			default: begin px = r_q; py = t_q; end
		endcase
	end

	bcmc_axis #(
		.COUNT       (CHUNK_COL_COUNT),
		.MASK_CELLS  (MASK_CELLS),
		.CHUNK_UNITS (CHUNK_UNITS),
		.WORLD_UNITS (WORLD_UNITS_X)
	) u_axis_x (
		.clk         (clk),
		.coord       (px),
		.in_world_s2 (xin_s2),
		.chunk_s2    (col_s2),
		.cell_s2     (mx_s2)
	);

	bcmc_axis #(
		.COUNT       (CHUNK_ROW_COUNT),
		.MASK_CELLS  (MASK_CELLS),
		.CHUNK_UNITS (CHUNK_UNITS),
		.WORLD_UNITS (WORLD_UNITS_Y)
	) u_axis_y (
		.clk         (clk),
		.coord       (py),
		.in_world_s2 (yin_s2),
		.chunk_s2    (row_s2),
		.cell_s2     (my_s2)
	);

	// Bit index of the cell: chunk-major, then row within chunk, then column.
	assign chunk_idx = CHK_W'(row_s2) * CHK_W'(CHUNK_COL_COUNT) + CHK_W'(col_s2);
	assign bit_idx   = BIT_W'(chunk_idx) * BIT_W'(MASK_CELLS * MASK_CELLS)
	                 + BIT_W'(my_s2) * BIT_W'(MASK_CELLS) + BIT_W'(mx_s2);

	// Stage 3: word address (wrapping over the store), bit select and solid flag, carried on to stage 4.
	always_ff @(posedge clk) begin
		addr_s3  <= bit_idx[19:5];
		sel_s3   <= bit_idx[4:0];
		solid_s3 <= !(xin_s2 && yin_s2);
		sel_s4   <= sel_s3;
		solid_s4 <= solid_s3;
	end

	// Point valid and last-point marks down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1.valid <= feed;
			tag_s1.last  <= (pc_q == '1);
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			tag_s4       <= tag_s3;
		end
	end

	bcmc_mask_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Stage 4: mask bit arrives; a point outside the world is solid.
	assign point_open = !solid_s4 && ram_rdata[sel_s4];

	// Accumulate the eight point results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 1'b1;
			done_q <= 1'b0;
		end else begin
			if (q_accept) begin
				acc_q  <= 1'b1;
				done_q <= 1'b0;
			end else begin
				if (tag_s4.valid) begin
					acc_q <= acc_q && point_open;
					if (tag_s4.last) done_q <= 1'b1;
				end
				if (out_load) done_q <= 1'b0;
			end
		end
	end

	// Output register toward the master stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			box_clear_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				box_clear_q <= !masks_loaded_q || acc_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, box_clear_q};

endmodule

`default_nettype wire

[hdl/bcmc_checker.sv]
// Port-level checker for the box collision mask checker, bound to its top.
// Depends on bcmc_pkg for stream widths and the item kind codes.
`timescale 1ns / 1ps
`default_nettype none

module bcmc_checker
	import bcmc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_axis_tvalid,
	input wire logic                 s_axis_tready,
	input wire logic [0:0]           s_axis_tuser,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic       q_xfer;
	logic       r_xfer;
	logic [1:0] pend_q;

	assign q_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_QUERY);
	assign r_xfer = m_axis_tvalid && m_axis_tready;

	// Queries taken whose result has not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(q_xfer) - 2'(r_xfer);
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// No result without a query that asked for it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result without a pending query");

	// At most one result waiting and one query in work.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> pend_q != 2'd3)
		else $error("too many queries outstanding");

	// A query occupies the block for its sample reads.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_xfer |=> !s_axis_tready)
		else $error("input taken during a query");

endmodule

bind box_collision_mask_check bcmc_checker u_bcmc_checker (.*);

`default_nettype wire

[test/box_collision_mask_check_tb.sv]
// Self-checking testbench for the box collision mask checker.
// Depends on bcmc_pkg and box_collision_mask_check; uses no files.
`timescale 1ns / 1ps

// Keeps a shadow copy of the mask store and the masks_loaded bit and
// predicts box_clear for every query transfer that the block accepts.
class mask_scoreboard;
	localparam longint GRID_ROWS  = 4;
	localparam longint GRID_COLS  = 4;
	localparam longint CELLS      = 256;
	localparam longint SPAN_Q4    = 1024 * 16;
	localparam longint WORLD_X_Q4 = 4096 * 16;
	localparam longint WORLD_Y_Q4 = 4096 * 16;
	localparam longint INSET      = 64;
	localparam int     DEPTH      = 32768;

	bit [31:0]   mask_words [DEPTH];
	bit          loaded;
	bit          clear_q [$];
	int unsigned errors;
	int unsigned writes_seen;
	int unsigned queries_seen;
	int unsigned clear_seen;
	int unsigned blocked_seen;

	function new();
		foreach (mask_words[i])
			mask_words[i] = '1;
		loaded = 0;
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// Chunk and cell along one axis of an in-world coordinate, both clamped.
	function automatic void locate(input longint p, input longint chunks,
			output longint chunk, output longint cell_idx);
		chunk = p / SPAN_Q4;
		if (chunk >= chunks)
			chunk = chunks - 1;
		cell_idx = ((p - chunk * SPAN_Q4) * CELLS) / SPAN_Q4;
		if (cell_idx < 0)
			cell_idx = 0;
		if (cell_idx >= CELLS)
			cell_idx = CELLS - 1;
	endfunction

	function automatic bit in_world(longint px, longint py);
		return px >= 0 && px < WORLD_X_Q4 && py >= 0 && py < WORLD_Y_Q4;
	endfunction

	function automatic longint bit_of(longint px, longint py);
		longint col, row, mx, my;
		locate(px, GRID_COLS, col, mx);
		locate(py, GRID_ROWS, row, my);
		return ((row * GRID_COLS + col) * CELLS + my) * CELLS + mx;
	endfunction

	function automatic int unsigned word_of(longint px, longint py);
		return int'((bit_of(px, py) >> 5) & (DEPTH - 1));
	endfunction

	// The eight inset sample points: bottom row, middle row, top row.
	function automatic void sample_point(input longint x, input longint y,
			input longint w, input longint h, input int k,
			output longint px, output longint py);
		longint lft, rgt, bot, top, cx, cy;
		lft = x + INSET;
		rgt = x + w * 16 - INSET;
		bot = y + INSET;
		top = y + h * 16 - INSET;
		cx  = x + w * 8;
		cy  = y + h * 8;
		case (k)
			0: begin px = lft; py = bot; end
			1: begin px = cx;  py = bot; end
			2: begin px = rgt; py = bot; end
			3: begin px = lft; py = cy;  end
			4: begin px = rgt; py = cy;  end
			5: begin px = lft; py = top; end
			6: begin px = cx;  py = top; end
			default: begin px = rgt; py = top; end
		endcase
	endfunction

	function automatic bit point_open(longint px, longint py);
		longint b;
		if (!loaded)
			return 1;
		if (!in_world(px, py))
			return 0;
		b = bit_of(px, py);
		return mask_words[(b >> 5) & (DEPTH - 1)][b & 31];
	endfunction

	// Applies one accepted input transfer to the shadow state.
	function void note_item(bcmc_pkg::cmd_t kind, logic [bcmc_pkg::S_TDATA_W-1:0] payload);
		longint x, y, w, h, px, py;
		bit open;
		if (kind == bcmc_pkg::CMD_WRITE) begin
			mask_words[payload[74:60]] = payload[106:75];
			writes_seen++;
			return;
		end
		x = $signed(payload[19:0]);
		y = $signed(payload[39:20]);
		w = payload[49:40];
		h = payload[59:50];
		open = 1;
		for (int k = 0; k < 8; k++) begin
			sample_point(x, y, w, h, k, px, py);
			if (!point_open(px, py))
				open = 0;
		end
		clear_q.push_back(open);
		queries_seen++;
		if (open)
			clear_seen++;
		else
			blocked_seen++;
	endfunction

	// Compares one result transfer with the oldest outstanding prediction.
	task check_result(logic [bcmc_pkg::M_TDATA_W-1:0] result);
		bit want;
		if (clear_q.size() == 0) begin
			report_mismatch($sformatf("result %0b with no query outstanding", result[0]));
			return;
		end
		want = clear_q.pop_front();
		if (result[0] !== want)
			report_mismatch($sformatf("box_clear is %b, predicted %b", result[0], want));
	endtask

	function int pending();
		return clear_q.size();
	endfunction
endclass

module box_collision_mask_check_tb;
	import bcmc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_we = 0;
	logic                 cfg_wdata = 0;
	logic                 s_axis_tvalid = 0;
	logic                 s_axis_tready;
	// pos_x, pos_y, box_width, box_height, mask_addr, mask_data, zero fill
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	// command
	logic [0:0]           s_axis_tuser = CMD_WRITE;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 0;
	// box_clear, zero fill
	logic [M_TDATA_W-1:0] m_axis_tdata;

	mask_scoreboard sb = new();
	int unsigned    cycle_count = 0;
	bit             tx_gaps = 0;
	bit             rx_gaps = 0;
	int             rx_hold = 0;

	box_collision_mask_check uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver back-pressure: random low bursts on m_axis_tready.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready = 0;
			rx_hold--;
		end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
			m_axis_tready = 0;
			rx_hold = $urandom_range(0, 3);
		end else begin
			m_axis_tready = 1;
		end
	end

	// Every result transfer is checked against the prediction queue.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	function automatic logic [S_TDATA_W-1:0] pack_item(int x, int y, int w, int h,
			int unsigned addr, logic [31:0] data);
		logic [19:0] xf, yf;
		logic [9:0]  wf, hf;
		logic [14:0] af;
		xf = x[19:0];
		yf = y[19:0];
		wf = w[9:0];
		hf = h[9:0];
		af = addr[14:0];
		return {5'b0, data, af, hf, wf, yf, xf};
	endfunction

	// Drives one input transfer, then maybe leaves a short gap.
	task send_item(cmd_t kind, logic [S_TDATA_W-1:0] payload);
		@(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tuser  = kind;
		s_axis_tdata  = payload;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_item(kind, payload);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_axis_tvalid = 0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
	endtask

	task send_query(int x, int y, int w, int h);
		send_item(CMD_QUERY, pack_item(x, y, w, h, $urandom, $urandom));
	endtask

	task send_write(int unsigned addr, logic [31:0] data);
		send_item(CMD_WRITE, pack_item($urandom, $urandom, $urandom, $urandom, addr, data));
	endtask

	// Holds the sender until all results are in and in-flight writes settle.
	task wait_drained();
		@(negedge clk);
		s_axis_tvalid = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_masks_loaded(bit value);
		wait_drained();
		@(negedge clk);
		cfg_we    = 1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 0;
		sb.loaded = value;
	endtask

	function automatic int rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return int'($urandom_range(0, 66559)) - 512;
		if (sel < 9)
			return $urandom_range(0, 1) ? int'($urandom_range(0, 130)) - 130
				: 65280 + int'($urandom_range(0, 400));
		return int'($signed($urandom_range(0, 20'hFFFFF) & 20'hFFFFF));
	endfunction

	function automatic int rand_size();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 15)
			return $urandom_range(0, 64);
		if (sel < 19)
			return $urandom_range(0, 1023);
		return $urandom_range(0, 1) ? 0 : 1023;
	endfunction

	function automatic logic [31:0] rand_mask_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return '1;
			2: return '0;
			default: return $urandom | $urandom;
		endcase
	endfunction

	// Mostly box queries, often preceded by a write to the word under one of
	// their sample points, plus some unrelated writes.
	task run_random(int count, bit allow_gaps);
		int x, y, w, h, k;
		longint px, py;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				tx_gaps = allow_gaps && $urandom_range(0, 2) != 0;
				rx_gaps = allow_gaps && $urandom_range(0, 2) != 0;
			end
			if (allow_gaps && i % 120 == 119)
				wait_drained();
			if ($urandom_range(0, 9) == 0) begin
				send_write($urandom_range(0, 32767), $urandom);
				continue;
			end
			x = rand_coord();
			y = rand_coord();
			w = rand_size();
			h = rand_size();
			if ($urandom_range(0, 9) < 6) begin
				k = $urandom_range(0, 7);
				sb.sample_point(longint'($signed(x[19:0])), longint'($signed(y[19:0])),
					w, h, k, px, py);
				if (sb.in_world(px, py)) begin
					send_write(sb.word_of(px, py), rand_mask_word());
					i++;
				end
			end
			send_query(x, y, w, h);
		end
	endtask

	// Directed items: field extremes, world edges, empty boxes, store ends.
	task run_directed();
		tx_gaps = 1;
		rx_gaps = 1;
		// Masks not loaded: everything is walkable, even outside the world.
		send_query(-524288, -524288, 0, 0);
		send_query(524287, 524287, 1023, 1023);
		send_query(-65, 70000, 16, 16);
		send_query(0, 0, 16, 16);
		write_masks_loaded(1);
		send_query(0, 0, 16, 16);
		send_write(sb.word_of(64, 64), 32'h0);
		send_query(0, 0, 16, 16);
		// Left edge exactly on the world boundary, then one step outside.
		send_query(-64, 1024, 16, 16);
		send_query(-65, 1024, 16, 16);
		// Top and right edges on the last in-world position, then past it.
		send_query(8192, 65343, 16, 16);
		send_query(8192, 65344, 16, 16);
		send_query(65343, 8192, 16, 16);
		send_query(65344, 8192, 16, 16);
		// Empty boxes sample points outside the box itself.
		send_query(4096, 4096, 0, 0);
		send_query(0, 4096, 0, 0);
		send_query(-524288, -524288, 0, 0);
		send_query(524287, 524287, 1023, 1023);
		send_query(4096, 4096, 1023, 1023);
		// First and last words of the store, cleared and restored.
		send_write(0, 32'h0);
		send_query(-64, -64, 16, 16);
		send_write(0, 32'hFFFF_FFFF);
		send_write(32767, 32'h0);
		send_query(65343, 65343, 16, 16);
		send_write(32767, 32'hFFFF_FFFF);
		send_query(65343, 65343, 16, 16);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_masks_loaded(0);
		run_directed();
		run_random(300, 1);
		write_masks_loaded(0);
		run_random(80, 1);
		write_masks_loaded(1);
		run_random(200, 0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d mask writes and %0d box queries (%0d clear, %0d blocked),",
			sb.writes_seen, sb.queries_seen, sb.clear_seen, sb.blocked_seen);
		$display("with masks_loaded at both values and random stalls on both streams.");
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
hdl/bcmc_pkg.sv
hdl/bcmc_mask_ram.sv
hdl/bcmc_axis.sv
hdl/box_collision_mask_check.sv
hdl/bcmc_checker.sv
test/box_collision_mask_check_tb.sv
